// File: src/ltaeb_pkg.sv
package ltaeb_pkg;

    localparam int DATA_W     = 16;
    localparam int CFG_ADDR_W = 2;

    localparam logic [DATA_W-1:0] TTC_NONE    = 16'hFFFF;
    localparam logic [DATA_W-1:0] TTC_THR_RST = 16'd500;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TTC_THR   = 2'd0,
        CFG_START_ANG = 2'd1,
        CFG_ANG_STEP  = 2'd2
    } t_cfg_reg;

    // cosine polynomial over a quarter turn, Q14 argument
    localparam logic signed [17:0] COS_K2   = 18'sd40426;
    localparam logic signed [17:0] COS_K4   = 18'sd8300;
    localparam logic signed [17:0] COS_K6   = 18'sd642;
    localparam logic signed [18:0] COS_ONE  = 19'sd32768;
    localparam logic signed [18:0] COS_MAX  = 19'sd32767;
    localparam logic signed [17:0] MS_PER_S = 18'sd1000;

endpackage

// File: src/ltaeb_if.sv
interface ltaeb_req_if
    import ltaeb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [DATA_W-1:0] speed_mm_s;
    logic        [DATA_W-1:0] beam_range_mm;
    logic                     beam_last;

    modport source (output valid, output req_type, output speed_mm_s,
                    output beam_range_mm, output beam_last, input ready);
    modport sink   (input valid, input req_type, input speed_mm_s,
                    input beam_range_mm, input beam_last, output ready);
endinterface

interface ltaeb_res_if
    import ltaeb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] min_ttc_ms;
    logic              brake;

    modport source (output valid, output min_ttc_ms, output brake, input ready);
    modport sink   (input valid, input min_ttc_ms, input brake, output ready);
endinterface

// File: src/lidar_ttc_emergency_brake.sv
// Time-to-collision emergency braking over one lidar scan.
// Request channel i_req: each transfer is a speed update (req_type 0) or one
// beam range (req_type 1, beam_last marks the end of the scan). Beams are
// numbered from zero; the beam angle is start + index * step, wrapping.
// Result channel o_res: one transfer per scan, on the last beam, with the
// smallest TTC of the scan in ms (65535 = none) and the brake request.
// Config port: i_cfg_wr_en / i_cfg_addr / i_cfg_wdata, write only, taken
// at any edge with the enable high; change it only while the block is idle.
// A speed update is taken in the idle state. A beam runs through one shared
// 18x18 multiplier (angle, cosine polynomial, closing rate, numerator), then
// a restoring divider that retires one quotient bit per cycle; the divider is
// skipped when the closing rate is not positive.
// i_req.ready is high only while the sequencer is idle.
// The result sits in an output register; a new scan may start while it waits.
// A last beam whose result finds that register still full holds until
// o_res.ready frees it.
// Reset (synchronous, active low) restores the threshold to 500 ms, zeroes
// angles, speed and beam index, and sets the running minimum to 65535.
module lidar_ttc_emergency_brake
    import ltaeb_pkg::*;
#(
    parameter int MAX_BEAMS = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata,
    ltaeb_req_if.sink             i_req,
    ltaeb_res_if.source           o_res
);

    localparam int IW = $clog2(MAX_BEAMS);

    typedef enum logic [3:0] {
        S_IDLE, S_IDX, S_ANG, S_ZZ, S_Z4, S_Z6, S_T6, S_T2, S_T4,
        S_CS, S_RATE, S_NUM, S_DINIT, S_DIV, S_FIN
    } t_state;

    t_state r_state;

    logic [DATA_W-1:0]        r_thr;
    logic [DATA_W-1:0]        r_start;
    logic [DATA_W-1:0]        r_step;

    logic signed [DATA_W-1:0] r_speed;
    logic [IW-1:0]            r_idx;
    logic [DATA_W-1:0]        r_min;

    logic [DATA_W-1:0]        r_range;
    logic                     r_last;
    logic [DATA_W-1:0]        r_angle;
    logic                     r_neg;
    logic [14:0]              r_z2;
    logic [14:0]              r_z4;
    logic signed [18:0]       r_acc;
    logic signed [DATA_W-1:0] r_cos;
    logic signed [35:0]       r_prod;
    logic [47:0]              r_dvs;
    logic [47:0]              r_rem;
    logic [16:0]              r_quo;
    logic [4:0]               r_cnt;
    logic                     r_inf;

    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_ttc;
    logic                     r_out_brake;

    logic signed [17:0]       w_mul_a;
    logic signed [17:0]       w_mul_b;
    logic signed [35:0]       w_rnd_full;
    logic signed [18:0]       w_rnd;
    logic [14:0]              w_z;
    logic signed [18:0]       w_sum;
    logic [14:0]              w_c;
    logic [DATA_W-1:0]        w_ttc;
    logic [DATA_W-1:0]        w_min_new;
    logic                     w_out_free;
    logic                     w_ge;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.min_ttc_ms = r_out_ttc;
    assign o_res.brake      = r_out_brake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= TTC_THR_RST;
            r_start <= '0;
            r_step  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_TTC_THR:   r_thr   <= i_cfg_wdata;
                CFG_START_ANG: r_start <= i_cfg_wdata;
                CFG_ANG_STEP:  r_step  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_rnd_full = (r_prod + 36'sd8192) >>> 14;
    assign w_rnd      = w_rnd_full[18:0];
    assign w_z        = r_angle[14] ? (15'd16384 - {1'b0, r_angle[13:0]})
                                    : {1'b0, r_angle[13:0]};
    assign w_sum      = r_acc + w_rnd;

    always_comb begin
        if (w_sum < 19'sd0) begin
            w_c = '0;
        end else if (w_sum > COS_MAX) begin
            w_c = COS_MAX[14:0];
        end else begin
            w_c = w_sum[14:0];
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDX: begin
                w_mul_a = $signed({2'b0, 16'(r_idx)});
                w_mul_b = $signed({2'b0, r_step});
            end
            S_ZZ: begin
                w_mul_a = $signed({3'b0, w_z});
                w_mul_b = $signed({3'b0, w_z});
            end
            S_Z4: begin
                w_mul_a = $signed({3'b0, w_rnd[14:0]});
                w_mul_b = $signed({3'b0, w_rnd[14:0]});
            end
            S_Z6: begin
                w_mul_a = $signed({3'b0, w_rnd[14:0]});
                w_mul_b = $signed({3'b0, r_z2});
            end
            S_T6: begin
                w_mul_a = $signed({3'b0, w_rnd[14:0]});
                w_mul_b = COS_K6;
            end
            S_T2: begin
                w_mul_a = $signed({3'b0, r_z2});
                w_mul_b = COS_K2;
            end
            S_T4: begin
                w_mul_a = $signed({3'b0, r_z4});
                w_mul_b = COS_K4;
            end
            S_RATE: begin
                w_mul_a = {{2{r_speed[15]}}, r_speed};
                w_mul_b = {{2{r_cos[15]}}, r_cos};
            end
            S_NUM: begin
                w_mul_a = $signed({2'b0, r_range});
                w_mul_b = MS_PER_S;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_ge       = (r_rem >= r_dvs);
    assign w_ttc      = (r_inf || r_quo[16]) ? TTC_NONE : r_quo[15:0];
    assign w_min_new  = (w_ttc < r_min) ? w_ttc : r_min;
    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_idx       <= '0;
            r_min       <= TTC_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && !(r_state == S_FIN && r_last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (!i_req.req_type) begin
                            r_speed <= i_req.speed_mm_s;
                        end else begin
                            r_range <= i_req.beam_range_mm;
                            r_last  <= i_req.beam_last;
                            r_state <= S_IDX;
                        end
                    end
                end
                S_IDX: r_state <= S_ANG;
                S_ANG: begin
                    r_angle <= r_start + r_prod[15:0];
                    r_state <= S_ZZ;
                end
                S_ZZ: begin
                    r_neg   <= r_angle[15] ^ r_angle[14];
                    r_state <= S_Z4;
                end
                S_Z4: begin
                    r_z2    <= w_rnd[14:0];
                    r_state <= S_Z6;
                end
                S_Z6: begin
                    r_z4    <= w_rnd[14:0];
                    r_state <= S_T6;
                end
                S_T6: begin
                    r_acc   <= COS_ONE;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_acc   <= r_acc - w_rnd;
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_acc   <= r_acc - w_rnd;
                    r_state <= S_CS;
                end
                S_CS: begin
                    r_cos   <= r_neg ? -$signed({1'b0, w_c}) : $signed({1'b0, w_c});
                    r_state <= S_RATE;
                end
                S_RATE: r_state <= S_NUM;
                S_NUM: begin
                    if (r_prod > 36'sd0) begin
                        r_inf   <= 1'b0;
                        r_dvs   <= {1'b0, r_prod[30:0], 16'b0};
                        r_state <= S_DINIT;
                    end else begin
                        r_inf   <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_DINIT: begin
                    r_rem   <= {7'b0, r_prod[25:0], 15'b0};
                    r_cnt   <= 5'd16;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_dvs;
                    end
                    r_quo <= {r_quo[15:0], w_ge};
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_min   <= w_min_new;
                        r_idx   <= (r_idx == IW'(MAX_BEAMS - 1)) ? '0 : r_idx + 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ttc   <= w_min_new;
                        r_out_brake <= (w_min_new < r_thr);
                        r_min       <= TTC_NONE;
                        r_idx       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_min == TTC_NONE && r_idx == '0 && !r_out_valid))
        else $error("reset did not clear scan state");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final step");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CS) |=> (r_cos != 16'sh8000))
        else $error("cosine out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_idx) < MAX_BEAMS)
        else $error("beam index past scan length");

endmodule
